/* src/csh_pkg.sv */
package csh_pkg;

    typedef enum logic [1:0] {
        MODE_SCAN = 2'd0,
        MODE_WAIT = 2'd1,
        MODE_CONN = 2'd2
    } mode_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CELL_ID_A         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_ID_B         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_ID_C         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RSSI          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_TICKS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_TICKS      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPERVISION_TICKS = 3'd6;

    localparam logic [7:0]         RST_CELL_ID_A         = 8'd145;
    localparam logic [7:0]         RST_CELL_ID_B         = 8'd208;
    localparam logic [7:0]         RST_CELL_ID_C         = 8'd89;
    localparam logic signed [7:0]  RST_MIN_RSSI          = -8'sd50;
    localparam logic [15:0]        RST_SCAN_TICKS        = 16'd5000;
    localparam logic [15:0]        RST_ACCEPT_TICKS      = 16'd10000;
    localparam logic [15:0]        RST_SUPERVISION_TICKS = 16'd5000;

    localparam logic signed [7:0]  SIGNAL_FLOOR          = -8'sd100;

    typedef struct packed {
        logic [7:0]  cell_id_a;
        logic [7:0]  cell_id_b;
        logic [7:0]  cell_id_c;
        logic [7:0]  min_rssi;
        logic [15:0] scan_ticks;
        logic [15:0] accept_ticks;
        logic [15:0] supervision_ticks;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] src_id;
        logic [7:0] rssi;
        logic       is_accept;
    } item_t;

endpackage

/* src/csh_item_if.sv */
interface csh_item_if;
    logic              valid;
    logic              ready;
    logic              func;
    logic [7:0]        src_id;
    logic signed [7:0] rssi;
    logic              is_accept;

    modport source (output valid, output func, output src_id, output rssi, output is_accept,
                    input ready);
    modport sink (input valid, input func, input src_id, input rssi, input is_accept,
                  output ready);
endinterface

/* src/csh_result_if.sv */
interface csh_result_if;
    logic       valid;
    logic       ready;
    logic       send_request;
    logic [7:0] request_dest;
    logic [1:0] link_state;
    logic [7:0] serving_cell;

    modport source (output valid, output send_request, output request_dest,
                    output link_state, output serving_cell, input ready);
    modport sink (input valid, input send_request, input request_dest,
                  input link_state, input serving_cell, output ready);
endinterface

/* src/csh_cfg_if.sv */
interface csh_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/cell_select_handover_fsm_unit.sv */
// A request accepted on the item channel goes to the input register, then to the result register.
// Throughput: one request per cycle while the result channel takes one per cycle.
// The input register and the result register each hold one request, so either side may stall.
// Reset is asynchronous and active low: it empties both registers, puts the machine in the
// scanning state and loads the configuration registers with their default values.
module cell_select_handover_fsm_unit (
    input  logic         clk,
    input  logic         rst_n,
    csh_item_if.sink     item,
    csh_result_if.source result,
    csh_cfg_if.sink      cfg
);
    import csh_pkg::*;

    cfg_t  cfg_regs;
    logic  stage_valid;
    item_t stage_item;
    logic  take;

    csh_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    csh_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    csh_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_regs),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .take        (take),
        .result      (result)
    );

`ifndef SYNTH
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> result.valid)
        else $error("A consumed request did not produce a result.");

    a_request_only_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.send_request) |-> (result.link_state == MODE_WAIT))
        else $error("A request was sent without moving to the awaiting-accept state.");

    a_idle_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.send_request) |-> (result.request_dest == 8'd0))
        else $error("Destination is nonzero while no request is sent.");

    a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !take)
        else $error("The machine advanced while its result was still pending.");
`endif
endmodule

/* src/csh_cfg_regs.sv */
module csh_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    csh_cfg_if.sink       cfg,
    output csh_pkg::cfg_t cfg_regs
);
    import csh_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_id_a         <= RST_CELL_ID_A;
            cfg_reg.cell_id_b         <= RST_CELL_ID_B;
            cfg_reg.cell_id_c         <= RST_CELL_ID_C;
            cfg_reg.min_rssi          <= RST_MIN_RSSI;
            cfg_reg.scan_ticks        <= RST_SCAN_TICKS;
            cfg_reg.accept_ticks      <= RST_ACCEPT_TICKS;
            cfg_reg.supervision_ticks <= RST_SUPERVISION_TICKS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CELL_ID_A:         cfg_reg.cell_id_a         <= cfg.data[7:0];
                REG_CELL_ID_B:         cfg_reg.cell_id_b         <= cfg.data[7:0];
                REG_CELL_ID_C:         cfg_reg.cell_id_c         <= cfg.data[7:0];
                REG_MIN_RSSI:          cfg_reg.min_rssi          <= cfg.data[7:0];
                REG_SCAN_TICKS:        cfg_reg.scan_ticks        <= cfg.data;
                REG_ACCEPT_TICKS:      cfg_reg.accept_ticks      <= cfg.data;
                REG_SUPERVISION_TICKS: cfg_reg.supervision_ticks <= cfg.data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end
endmodule

/* src/csh_in_stage.sv */
module csh_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    csh_item_if.sink       item,
    input  logic           take,
    output logic           stage_valid,
    output csh_pkg::item_t stage_item
);
    import csh_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign item.ready  = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.func      <= item.func;
            item_reg.src_id    <= item.src_id;
            item_reg.rssi      <= item.rssi;
            item_reg.is_accept <= item.is_accept;
        end
    end
endmodule

/* src/csh_fsm.sv */
module csh_fsm (
    input  logic           clk,
    input  logic           rst_n,
    input  csh_pkg::cfg_t  cfg_regs,
    input  logic           stage_valid,
    input  csh_pkg::item_t stage_item,
    output logic           take,
    csh_result_if.source   result
);
    import csh_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [15:0]       tick_count_reg, tick_count_next;
    logic [7:0]        best_cell_reg, best_cell_next;
    logic signed [7:0] best_signal_reg, best_signal_next;
    logic              have_cand_reg, have_cand_next;
    logic [7:0]        target_cell_reg, target_cell_next;
    logic [7:0]        attached_cell_reg, attached_cell_next;

    logic              res_valid_reg;
    logic              send_reg, send_next;
    logic [7:0]        dest_reg, dest_next;
    logic [1:0]        link_state_reg;
    logic [7:0]        serving_reg;

    logic              is_known;
    logic [15:0]       tick_inc;
    logic signed [7:0] sig;
    logic signed [7:0] limit;
    logic              above_limit;
    logic              above_best;

    assign take = stage_valid && (!res_valid_reg || result.ready);

    assign sig         = $signed(stage_item.rssi);
    assign limit       = $signed(cfg_regs.min_rssi);
    assign above_limit = sig > limit;
    assign above_best  = sig > best_signal_reg;
    assign tick_inc    = tick_count_reg + 16'd1;
    assign is_known    = (stage_item.src_id == cfg_regs.cell_id_a)
                      || (stage_item.src_id == cfg_regs.cell_id_b)
                      || (stage_item.src_id == cfg_regs.cell_id_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_SCAN;
            tick_count_reg    <= 16'd0;
            best_cell_reg     <= 8'd0;
            best_signal_reg   <= SIGNAL_FLOOR;
            have_cand_reg     <= 1'b0;
            target_cell_reg   <= 8'd0;
            attached_cell_reg <= 8'd0;
        end
        else if (take)
        begin
            mode_reg          <= mode_next;
            tick_count_reg    <= tick_count_next;
            best_cell_reg     <= best_cell_next;
            best_signal_reg   <= best_signal_next;
            have_cand_reg     <= have_cand_next;
            target_cell_reg   <= target_cell_next;
            attached_cell_reg <= attached_cell_next;
        end
    end

    always_comb
    begin
        mode_next          = mode_reg;
        tick_count_next    = tick_count_reg;
        best_cell_next     = best_cell_reg;
        best_signal_next   = best_signal_reg;
        have_cand_next     = have_cand_reg;
        target_cell_next   = target_cell_reg;
        attached_cell_next = attached_cell_reg;
        send_next          = 1'b0;
        dest_next          = 8'd0;

        case (mode_reg)
            MODE_SCAN:
            begin
                if (!stage_item.func)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg_regs.scan_ticks)
                    begin
                        tick_count_next = 16'd0;
                        if (have_cand_reg)
                        begin
                            target_cell_next = best_cell_reg;
                            send_next        = 1'b1;
                            dest_next        = best_cell_reg;
                            mode_next        = MODE_WAIT;
                        end
                        else
                        begin
                            best_signal_next = SIGNAL_FLOOR;
                            have_cand_next   = 1'b0;
                        end
                    end
                end
                else if (is_known && above_limit && above_best)
                begin
                    best_cell_next   = stage_item.src_id;
                    best_signal_next = sig;
                    have_cand_next   = 1'b1;
                end
            end
            MODE_WAIT:
            begin
                if (!stage_item.func)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg_regs.accept_ticks)
                    begin
                        mode_next        = MODE_SCAN;
                        tick_count_next  = 16'd0;
                        best_signal_next = SIGNAL_FLOOR;
                        have_cand_next   = 1'b0;
                    end
                end
                else if (stage_item.is_accept)
                begin
                    attached_cell_next = target_cell_reg;
                    mode_next          = MODE_CONN;
                    tick_count_next    = 16'd0;
                end
            end
            MODE_CONN:
            begin
                if (!stage_item.func)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg_regs.supervision_ticks)
                    begin
                        mode_next        = MODE_SCAN;
                        tick_count_next  = 16'd0;
                        best_signal_next = SIGNAL_FLOOR;
                        have_cand_next   = 1'b0;
                    end
                end
                else if (stage_item.src_id == attached_cell_reg)
                begin
                    best_signal_next = sig;
                    if (above_limit)
                    begin
                        tick_count_next = 16'd0;
                    end
                end
                else if (is_known && above_best)
                begin
                    target_cell_next = stage_item.src_id;
                    send_next        = 1'b1;
                    dest_next        = stage_item.src_id;
                    mode_next        = MODE_WAIT;
                    tick_count_next  = 16'd0;
                end
            end
            default:
            begin
                mode_next        = MODE_SCAN;
                tick_count_next  = 16'd0;
                best_signal_next = SIGNAL_FLOOR;
                have_cand_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            send_reg       <= send_next;
            dest_reg       <= dest_next;
            link_state_reg <= mode_next;
            serving_reg    <= attached_cell_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.send_request = send_reg;
    assign result.request_dest = dest_reg;
    assign result.link_state   = link_state_reg;
    assign result.serving_cell = serving_reg;
endmodule
